[hdl/tbtc_pkg.sv]
// tbtc_pkg: beat types and symbol tables for the two byte / three char text codec
// no dependencies; imported by two_byte_three_char_text_codec
`default_nettype none

package tbtc_pkg;

  typedef struct packed {
    logic [7:0] in_value;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_last;
    logic       error;
  } out_beat_t;

  // most results one input beat can cause
  localparam int unsigned MaxResults = 3;

  localparam logic [5:0] SymLowerEnd = 6'd26;
  localparam logic [5:0] SymUpperEnd = 6'd52;
  localparam logic [5:0] SymDigitEnd = 6'd62;
  localparam logic [5:0] SymColon    = 6'd62;
  localparam logic [5:0] SymSemi     = 6'd63;
  localparam logic [5:0] SymOddMark  = 6'd1;

  // sextet value to ascii symbol
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < SymLowerEnd) begin
      c = 8'(8'h61 + {2'b00, v});
    end else if (v < SymUpperEnd) begin
      c = 8'(8'h41 + {2'b00, v - SymLowerEnd});
    end else if (v < SymDigitEnd) begin
      c = 8'(8'h30 + {2'b00, v - SymUpperEnd});
    end else if (v == SymColon) begin
      c = 8'h3A;
    end else begin
      c = 8'h3B;
    end
    return c;
  endfunction

  // ascii character to sextet value, anything outside the alphabet is zero
  function automatic logic [5:0] char_sym(input logic [7:0] c);
    logic [5:0] s;
    if (c >= 8'h61 && c <= 8'h7A) begin
      s = 6'(c - 8'h61);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      s = 6'(c - 8'h41 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h3A) begin
      s = SymColon;
    end else if (c == 8'h3B) begin
      s = SymSemi;
    end else begin
      s = 6'd0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/two_byte_three_char_text_codec.sv]
// two_byte_three_char_text_codec: byte pair <-> three symbol text codec, one module
// depends on tbtc_pkg for beat types and symbol tables
`default_nettype none

// channel   dir  handshake              payload
// in        in   in_valid / in_ready    in_data  (in_beat_t)
// out       out  out_valid / out_ready  out_data (out_beat_t)
// cfg       in   cfg_we                 cfg_data (direction)
//
// each input beat is decoded in the cycle it is taken and its zero to three results
// land in a three slot result buffer, seen on out_data the next cycle, one beat a cycle
// while out_ready is high. a new input beat is taken when the buffer is empty or its
// last entry leaves in the same cycle. reset (rst_n low, synchronous) clears the
// direction to encode, the group position and the buffer. out_ready low holds the
// buffer, and the input too unless the buffer is empty.

module two_byte_three_char_text_codec
  import tbtc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data
);

  typedef enum logic [1:0] {
    PosStart,
    PosOne,
    PosTwo
  } pos_t;

  logic       direction_r;
  pos_t       pos_r, pos_nxt;
  logic [7:0] held_r, held_nxt;
  logic [5:0] first_r, first_nxt;
  logic [5:0] second_r, second_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  out_beat_t  buf_r [MaxResults];
  out_beat_t  buf_nxt [MaxResults];

  out_beat_t  res [MaxResults];
  logic [1:0] n_res;
  logic       push, pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[0];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign push      = in_valid && in_ready;

  // work out the results and the next group state for the beat on the input
  always_comb begin
    logic [7:0] v;
    logic [5:0] s;
    v = in_data.in_value;
    s = char_sym(v);
    pos_nxt    = pos_r;
    held_nxt   = held_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    n_res      = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end
    if (!direction_r) begin
      if (pos_r != PosOne) begin
        if (!in_data.in_last) begin
          held_nxt = v;
          pos_nxt  = PosOne;
        end else begin
          // lone final byte, odd marker as third symbol
          res[0].out_value = sym_char(v[7:2]);
          res[1].out_value = sym_char({v[1:0], 4'b0000});
          res[2].out_value = sym_char(SymOddMark);
          res[2].out_last  = 1'b1;
          n_res   = 2'd3;
          pos_nxt = PosStart;
        end
      end else begin
        res[0].out_value = sym_char(held_r[7:2]);
        res[1].out_value = sym_char({held_r[1:0], v[7:4]});
        res[2].out_value = sym_char({1'b0, v[3:0], 1'b0});
        res[2].out_last  = in_data.in_last;
        n_res   = 2'd3;
        pos_nxt = PosStart;
      end
    end else begin
      if (pos_r != PosTwo) begin
        if (in_data.in_last) begin
          // stream ended inside a group
          res[0].out_last = 1'b1;
          res[0].error    = 1'b1;
          n_res   = 2'd1;
          pos_nxt = PosStart;
        end else if (pos_r == PosOne) begin
          second_nxt = s;
          pos_nxt    = PosTwo;
        end else begin
          first_nxt = s;
          pos_nxt   = PosOne;
        end
      end else begin
        res[0].out_value = {first_r, second_r[5:4]};
        res[1].out_value = {second_r[3:0], 4'b0000} | {3'b000, s[5:1]};
        pos_nxt = PosStart;
        if (in_data.in_last && s[0]) begin
          res[0].out_last = 1'b1;
          n_res = 2'd1;
        end else begin
          res[1].out_last = in_data.in_last;
          n_res = 2'd2;
        end
      end
    end
  end

  // result buffer: a push only happens once the buffer has drained or its last entry leaves
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < MaxResults; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (push) begin
      cnt_nxt = n_res;
      for (int i = 0; i < MaxResults; i++) begin
        buf_nxt[i] = res[i];
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxResults; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    if (!rst_n) begin
      direction_r <= 1'b0;
      pos_r       <= PosStart;
      held_r      <= '0;
      first_r     <= '0;
      second_r    <= '0;
      cnt_r       <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        direction_r <= cfg_data;
        pos_r       <= PosStart;
      end else if (push) begin
        pos_r    <= pos_nxt;
        held_r   <= held_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/two_byte_three_char_text_codec_tb.sv]
// two_byte_three_char_text_codec_tb: self-checking bench for the byte pair / three symbol codec
// drives random and directed beats in both directions and checks results against a local predictor
// depends on tbtc_pkg and two_byte_three_char_text_codec
`timescale 1ns / 100ps

module two_byte_three_char_text_codec_tb;
  import tbtc_pkg::*;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;
  localparam int   StallLimit = 500;
  localparam int   ShownMismatches = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_data = 1'b0;

  // predictor state
  logic       dir_mode = DirEncode;
  logic [7:0] held_byte = '0;
  logic [1:0] grp_pos = '0;
  logic [5:0] first_sym = '0;
  logic [5:0] second_sym = '0;

  in_beat_t  beats_to_send[$];
  out_beat_t awaited_beats[$];
  int        beats_left = 0;
  int        beats_queued = 0;
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        in_hold = 0;
  int        out_hold = 0;
  logic      in_took = 1'b0;
  logic      calm = 1'b0;

  two_byte_three_char_text_codec u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
    if (s < 6'd26) return 8'h61 + 8'(s);
    if (s < 6'd52) return 8'h41 + 8'(s - 6'd26);
    if (s < 6'd62) return 8'h30 + 8'(s - 6'd52);
    if (s == 6'd62) return 8'h3a;
    return 8'h3b;
  endfunction

  function automatic logic [5:0] ascii_to_sextet(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) return 6'(c - 8'h61);
    if (c >= 8'h41 && c <= 8'h5a) return 6'(c - 8'h41 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52);
    if (c == 8'h3a) return 6'd62;
    if (c == 8'h3b) return 6'd63;
    return 6'd0;
  endfunction

  task automatic await_beat(input logic [7:0] v, input logic l, input logic e);
    out_beat_t b;
    b.out_value = v;
    b.out_last  = l;
    b.error     = e;
    awaited_beats.insert(awaited_beats.size(), b);
  endtask

  // works out the result beats of one accepted input beat
  task automatic translate_beat(input in_beat_t b);
    logic [7:0] v;
    logic       lst;
    logic [5:0] s;
    logic [7:0] byte0;
    logic [7:0] byte1;
    v   = b.in_value;
    lst = b.in_last;
    if (dir_mode == DirEncode) begin
      if (grp_pos != 2'd1) begin
        if (!lst) begin
          held_byte = v;
          grp_pos = 2'd1;
        end else begin
          // lone closing byte, odd length marker as third symbol
          await_beat(sextet_to_ascii(v[7:2]), 1'b0, 1'b0);
          await_beat(sextet_to_ascii({v[1:0], 4'b0000}), 1'b0, 1'b0);
          await_beat(sextet_to_ascii(SymOddMark), 1'b1, 1'b0);
          grp_pos = 2'd0;
        end
      end else begin
        await_beat(sextet_to_ascii(held_byte[7:2]), 1'b0, 1'b0);
        await_beat(sextet_to_ascii({held_byte[1:0], v[7:4]}), 1'b0, 1'b0);
        await_beat(sextet_to_ascii({1'b0, v[3:0], 1'b0}), lst, 1'b0);
        grp_pos = 2'd0;
      end
    end else begin
      s = ascii_to_sextet(v);
      if (grp_pos == 2'd2) begin
        byte0 = {first_sym, second_sym[5:4]};
        // p3 >> 1 overlaps bit 4 of the low nibble shift
        byte1 = {second_sym[3:0], 4'b0000} | {3'b000, s[5:1]};
        grp_pos = 2'd0;
        if (lst && s[0]) begin
          await_beat(byte0, 1'b1, 1'b0);
        end else begin
          await_beat(byte0, 1'b0, 1'b0);
          await_beat(byte1, lst, 1'b0);
        end
      end else if (lst) begin
        // stream ends mid-group
        grp_pos = 2'd0;
        await_beat(8'h00, 1'b1, 1'b1);
      end else if (grp_pos == 2'd1) begin
        second_sym = s;
        grp_pos = 2'd2;
      end else begin
        first_sym = s;
        grp_pos = 2'd1;
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (in_hold > 0) begin
        in_valid <= 1'b0;
        in_hold = in_hold - 1;
      end else if (beats_to_send.size() != 0) begin
        in_data <= beats_to_send.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) in_hold = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) out_hold = $urandom_range(1, 10);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        translate_beat(in_data);
        beats_left = beats_left - 1;
      end
      if (out_valid && out_ready) begin
        if (awaited_beats.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= ShownMismatches)
            $display("unexpected beat: value %h last %b error %b",
                     out_data.out_value, out_data.out_last, out_data.error);
        end else begin
          want = awaited_beats.pop_front();
          if (out_data.out_value !== want.out_value || out_data.out_last !== want.out_last ||
              out_data.error !== want.error) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= ShownMismatches)
              $display("mismatch: want value %h last %b error %b, got value %h last %b error %b",
                       want.out_value, want.out_last, want.error,
                       out_data.out_value, out_data.out_last, out_data.error);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_beat(input logic [7:0] v, input logic l);
    in_beat_t b;
    b.in_value = v;
    b.in_last  = l;
    beats_to_send.insert(beats_to_send.size(), b);
    beats_left = beats_left + 1;
    beats_queued = beats_queued + 1;
  endtask

  // waits until every beat is taken and every result has come, then a short pause
  task automatic settle();
    @(negedge clk);
    while (beats_left != 0 || in_valid || awaited_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_direction(input logic d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= d;
    dir_mode = d;
    grp_pos = 2'd0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_stream();
    int n;
    int k;
    int r;
    logic [7:0] v;
    if (dir_mode == DirEncode) begin
      n = $urandom_range(1, 9);
      for (k = 0; k < n; k++)
        queue_beat(8'($urandom_range(0, 255)), (k == n - 1) && ($urandom_range(0, 5) != 0));
    end else begin
      n = 3 * $urandom_range(1, 3);
      r = $urandom_range(0, 9);
      if (r == 0) n = $urandom_range(1, 8);
      else if (r < 3) n = n - $urandom_range(1, 2);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 6) == 0) v = 8'($urandom_range(0, 255));
        else v = sextet_to_ascii(6'($urandom_range(0, 63)));
        queue_beat(v, k == n - 1);
      end
    end
  endtask

  initial begin
    int ph;
    int phase_start;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // encode straight out of reset
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hff, 1'b0);
    queue_beat(8'ha5, 1'b1);
    queue_beat(8'h3c, 1'b0);
    queue_beat(8'hc3, 1'b1);
    queue_beat(8'h12, 1'b0);
    settle();
    // held byte is dropped by the register write
    set_direction(DirEncode);
    queue_beat(8'h80, 1'b1);
    settle();

    set_direction(DirDecode);
    queue_beat(":", 1'b0);
    queue_beat(":", 1'b0);
    queue_beat(";", 1'b0);
    queue_beat("A", 1'b0);
    queue_beat("9", 1'b0);
    queue_beat("0", 1'b0);
    queue_beat("z", 1'b0);
    queue_beat("Z", 1'b0);
    queue_beat("9", 1'b1);
    queue_beat(8'hff, 1'b0);
    queue_beat("!", 1'b0);
    queue_beat(8'h80, 1'b1);
    queue_beat("Q", 1'b1);
    queue_beat("Q", 1'b0);
    queue_beat("b", 1'b1);
    queue_beat("x", 1'b0);
    queue_beat("y", 1'b0);
    settle();
    set_direction(DirDecode);
    queue_beat("0", 1'b0);
    queue_beat("9", 1'b0);
    queue_beat("a", 1'b1);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      calm = (ph == 2) || (ph == 5);
      set_direction((ph == 1 || ph == 2 || ph == 4) ? DirDecode : DirEncode);
      phase_start = beats_queued;
      while (beats_queued - phase_start < 20) fill_stream();
      settle();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && awaited_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
